FILE: design/sqm_pkg.sv
// ----------------------------------------------------------------------------
// sqm_pkg
// Shared types, register indexes and helpers for the string query matcher.
// ----------------------------------------------------------------------------
package sqm_pkg;

    localparam int QUERY_MAX_DEF = 16;
    localparam int QUERY_BYTES   = 16;
    localparam int CHAR_W        = 8;
    localparam int LEN_W         = 5;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int WORD_W        = 64;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_QUERY_LOW  = 3'd0;
    localparam t_cfg_index CFG_QUERY_HIGH = 3'd1;
    localparam t_cfg_index CFG_QUERY_LEN  = 3'd2;
    localparam t_cfg_index CFG_MODE       = 3'd3;
    localparam t_cfg_index CFG_CASE_FOLD  = 3'd4;

    typedef enum logic [1:0] {
        MODE_PREFIX    = 2'd0,
        MODE_SUBSTRING = 2'd1,
        MODE_FUZZY     = 2'd2,
        MODE_UNUSED    = 2'd3
    } t_mode;

    typedef struct packed {
        logic [WORD_W-1:0] query_low;
        logic [WORD_W-1:0] query_high;
        logic [LEN_W-1:0]  query_len;
        t_mode             mode;
        logic              fold;
    } t_cfg;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              present;
        logic              last;
    } t_item;

    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                    input logic en);
        logic [CHAR_W-1:0] r;
        r = c;
        if (en && (c >= 8'h41) && (c <= 8'h5A)) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

FILE: design/sqm_cfg_regs.sv
// ----------------------------------------------------------------------------
// sqm_cfg_regs
// Configuration register file: query bytes, length, mode and case fold.
// ----------------------------------------------------------------------------
module sqm_cfg_regs
    import sqm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  t_cfg_index            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_QUERY_LOW:  r_cfg.query_low  <= i_cfg_data[WORD_W-1:0];
                CFG_QUERY_HIGH: r_cfg.query_high <= i_cfg_data[WORD_W-1:0];
                CFG_QUERY_LEN:  r_cfg.query_len  <= i_cfg_data[LEN_W-1:0];
                CFG_MODE:       r_cfg.mode       <= t_mode'(i_cfg_data[1:0]);
                CFG_CASE_FOLD:  r_cfg.fold       <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/sqm_match_engine.sv
// ----------------------------------------------------------------------------
// sqm_match_engine
// Running match state per text and the verdict on the final character.
// ----------------------------------------------------------------------------
module sqm_match_engine
    import sqm_pkg::*;
#(
    parameter int QUERY_MAX = QUERY_MAX_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_step,
    input  t_item i_item,
    output logic  o_matched
);

    localparam int QW = $clog2(QUERY_MAX + 1);
    localparam int IW = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;

    logic [QW-1:0]             r_pos, n_pos;
    logic                      r_failed, n_failed;
    logic [QUERY_MAX-1:0]      r_pmb, n_pmb;
    logic                      r_found, n_found;

    logic [2*WORD_W-1:0]       w_query_all;
    logic [QW-1:0]             w_len;
    logic [QW-1:0]             w_len_dec;
    logic [CHAR_W-1:0]         w_char;
    logic [QUERY_MAX-1:0]      w_eq;
    logic                      w_pos_in;
    logic                      w_pos_hit;

    assign w_query_all = {i_cfg.query_high, i_cfg.query_low};
    assign w_len       = (i_cfg.query_len > LEN_W'(QUERY_MAX)) ? QW'(QUERY_MAX)
                                                               : i_cfg.query_len[QW-1:0];
    assign w_len_dec   = w_len - 1'b1;
    assign w_char      = fold_char(i_item.text_char, i_cfg.fold);

    // parallel compare against every query byte in use
    always_comb begin
        for (int i = 0; i < QUERY_MAX; i++) begin
            w_eq[i] = (fold_char(w_query_all[CHAR_W*i +: CHAR_W], i_cfg.fold) == w_char)
                      && (QW'(i) < w_len);
        end
    end

    assign w_pos_in  = (r_pos < w_len);
    assign w_pos_hit = w_pos_in && w_eq[r_pos[IW-1:0]];

    always_comb begin
        n_pos    = r_pos;
        n_failed = r_failed;
        n_pmb    = r_pmb;
        n_found  = r_found;
        if (i_step && i_item.present) begin
            unique case (i_cfg.mode)
                MODE_PREFIX: begin
                    if (w_pos_in && !w_pos_hit) begin
                        n_failed = 1'b1;
                    end
                    if (r_pos < QW'(QUERY_MAX)) begin
                        n_pos = r_pos + 1'b1;
                    end
                end
                MODE_SUBSTRING: begin
                    if (w_len != '0) begin
                        n_pmb = ((r_pmb << 1) | QUERY_MAX'(1)) & w_eq;
                        if (n_pmb[w_len_dec[IW-1:0]]) begin
                            n_found = 1'b1;
                        end
                    end
                end
                MODE_FUZZY: begin
                    if (w_pos_hit) begin
                        n_pos = r_pos + 1'b1;
                    end
                end
                MODE_UNUSED: begin
                end
            endcase
        end
    end

    always_comb begin
        if (w_len == '0) begin
            o_matched = 1'b1;
        end else begin
            unique case (i_cfg.mode)
                MODE_PREFIX:    o_matched = !n_failed && (n_pos >= w_len);
                MODE_SUBSTRING: o_matched = n_found;
                MODE_FUZZY:     o_matched = (n_pos >= w_len);
                MODE_UNUSED:    o_matched = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_failed <= 1'b0;
            r_pmb    <= '0;
            r_found  <= 1'b0;
        end else if (i_step && i_item.last) begin
            r_pos    <= '0;
            r_failed <= 1'b0;
            r_pmb    <= '0;
            r_found  <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_failed <= n_failed;
            r_pmb    <= n_pmb;
            r_found  <= n_found;
        end
    end

    // state is back to reset after the final character of a text
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.last) |=> (r_pos == '0 && !r_failed && r_pmb == '0 && !r_found))
        else $error("match state not cleared after end of text");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= QW'(QUERY_MAX))
        else $error("query position beyond query maximum");

    // an item without a character leaves the state untouched
    a_no_char_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_item.present && !i_item.last) |=>
            ($stable(r_pos) && $stable(r_failed) && $stable(r_pmb) && $stable(r_found)))
        else $error("state changed on item without a character");

endmodule

FILE: design/string_query_matcher_core.sv
// ----------------------------------------------------------------------------
// string_query_matcher_core
// Streams the characters of a text and reports whether a configured query
// matches it as prefix, contiguous substring or in-order subsequence.
//
// Usage: write the query bytes, length, mode and case fold over the cfg
// channel while no text is in flight (ready is always high). Then send the
// text one character per slave transaction: tdata carries the character,
// tuser flags that a character is present (low for an empty text), tlast
// marks the final transaction of the text. On that final transaction one
// master transaction returns the verdict in tdata bit 0.
// The final character is held in the input register, and its verdict is
// registered in the verdict register when that character moves on.
// Throughput: one character per cycle unless a final one waits on a full
// verdict register; the update checks all query bytes in parallel.
// Reset clears configuration and match state. A stalled receiver holds the
// verdict; characters other than the final one keep flowing, and a final one
// waits in the input register until the verdict register frees up.
// ----------------------------------------------------------------------------
module string_query_matcher_core
    import sqm_pkg::*;
#(
    parameter int QUERY_MAX = QUERY_MAX_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [CHAR_W-1:0]      s_axis_tdata,   // text_char
    input  logic                   s_axis_tuser,   // char_present
    input  logic                   s_axis_tlast,   // end_of_text
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata    // matched, then zero fill
);

    t_cfg  w_cfg;
    t_item r_in;
    logic  r_in_valid;
    logic  r_out_valid;
    logic  r_out_matched;
    logic  w_advance;
    logic  w_accept;
    logic  w_matched;

    assign o_cfg_ready = 1'b1;

    sqm_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    sqm_match_engine #(
        .QUERY_MAX (QUERY_MAX)
    ) u_match_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_step    (w_advance),
        .i_item    (r_in),
        .o_matched (w_matched)
    );

    // only a final character needs room in the verdict register
    assign w_advance     = r_in_valid && (!r_in.last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.text_char <= s_axis_tdata;
            r_in.present   <= s_axis_tuser;
            r_in.last      <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in.last) begin
            r_out_matched <= w_matched;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_matched};

    // a verdict only appears after a final character leaves the input stage
    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_advance && r_in.last))
        else $error("verdict without end of text");

    // characters that do not end a text never stall
    a_mid_text_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in.last) |-> (w_advance && s_axis_tready))
        else $error("mid-text character stalled");

    // a stalled verdict stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("verdict changed while stalled");

endmodule

FILE: dv/query_match_checker.sv
// ----------------------------------------------------------------------------
// query_match_checker
// Watches the register channel, text stream and verdict stream of the
// string query matcher, keeps its own copy of the query settings and the
// per-text match state, predicts each verdict when a text's last transaction
// is taken and compares every returned verdict against the oldest prediction.
// ----------------------------------------------------------------------------
module query_match_checker
    import sqm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [CHAR_W-1:0]      i_s_tdata,
    input  logic                   i_s_tuser,
    input  logic                   i_s_tlast,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [7:0]             i_m_tdata,
    output int                     o_errors,
    output int                     o_pending,
    output int                     o_checked,
    output int                     o_hits
);

    localparam int VERDICT_DEPTH = 64;

    logic [WORD_W-1:0]      q_low;
    logic [WORD_W-1:0]      q_high;
    logic [LEN_W-1:0]       q_len;
    t_mode                  q_mode;
    logic                   q_fold;

    logic [LEN_W-1:0]       scan_pos;
    logic                   prefix_broken;
    logic [QUERY_BYTES-1:0] run_bits;
    logic                   occurrence_seen;

    logic                   verdict_mem[VERDICT_DEPTH];
    int                     verdict_wr;
    int                     verdict_rd;

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        return (q_fold && (c >= 8'h41) && (c <= 8'h5A)) ? c + 8'h20 : c;
    endfunction

    function automatic logic [7:0] query_char(input int k);
        logic [WORD_W-1:0] word;
        word = (k < 8) ? q_low : q_high;
        return lower_ascii(word[8*(k%8) +: 8]);
    endfunction

    function automatic int span();
        return (q_len > QUERY_MAX_DEF) ? QUERY_MAX_DEF : int'(q_len);
    endfunction

    task automatic absorb_char(input logic [7:0] raw);
        logic [7:0]             c;
        logic [QUERY_BYTES-1:0] hits;
        int                     n;
        n = span();
        c = lower_ascii(raw);
        case (q_mode)
            MODE_PREFIX: begin
                if ((scan_pos < n) && (query_char(scan_pos) != c)) prefix_broken = 1'b1;
                if (scan_pos < QUERY_MAX_DEF) scan_pos = scan_pos + 1'b1;
            end
            MODE_SUBSTRING: begin
                if (n != 0) begin
                    hits = '0;
                    for (int k = 0; k < n; k++) hits[k] = (query_char(k) == c);
                    run_bits = ((run_bits << 1) | 16'd1) & hits;
                    if (run_bits[n-1]) occurrence_seen = 1'b1;
                end
            end
            MODE_FUZZY: begin
                if ((scan_pos < n) && (query_char(scan_pos) == c)) scan_pos = scan_pos + 1'b1;
            end
            default: ;
        endcase
    endtask

    function automatic logic text_verdict();
        int n;
        n = span();
        if (n == 0) return 1'b1;
        case (q_mode)
            MODE_PREFIX:    return !prefix_broken && (scan_pos >= n);
            MODE_SUBSTRING: return occurrence_seen;
            MODE_FUZZY:     return scan_pos >= n;
            default:        return 1'b0;
        endcase
    endfunction

    task automatic clear_text();
        scan_pos        = '0;
        prefix_broken   = 1'b0;
        run_bits        = '0;
        occurrence_seen = 1'b0;
    endtask

    task automatic report_mismatch(input string msg);
        $display("verdict %0d: %s", o_checked, msg);
        o_errors++;
    endtask

    always @(posedge i_clk) begin : watch
        logic want;
        if (!i_rst_n) begin
            q_low      = '0;
            q_high     = '0;
            q_len      = '0;
            q_mode     = MODE_PREFIX;
            q_fold     = 1'b0;
            clear_text();
            verdict_wr = 0;
            verdict_rd = 0;
            o_errors   = 0;
            o_pending  = 0;
            o_checked  = 0;
            o_hits     = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_QUERY_LOW:  q_low  = i_cfg_data;
                    CFG_QUERY_HIGH: q_high = i_cfg_data;
                    CFG_QUERY_LEN:  q_len  = i_cfg_data[LEN_W-1:0];
                    CFG_MODE:       q_mode = t_mode'(i_cfg_data[1:0]);
                    CFG_CASE_FOLD:  q_fold = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (verdict_wr == verdict_rd) begin
                    report_mismatch($sformatf("tdata %h with no text waiting", i_m_tdata));
                end else begin
                    want = verdict_mem[verdict_rd % VERDICT_DEPTH];
                    verdict_rd++;
                    if (i_m_tdata !== {7'b0, want}) begin
                        report_mismatch($sformatf("tdata %h, expected matched %0d",
                                                  i_m_tdata, want));
                    end
                    if (want) o_hits++;
                end
                o_checked++;
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser) absorb_char(i_s_tdata);
                if (i_s_tlast) begin
                    verdict_mem[verdict_wr % VERDICT_DEPTH] = text_verdict();
                    verdict_wr++;
                    clear_text();
                end
            end
            o_pending = verdict_wr - verdict_rd;
        end
    end

endmodule

FILE: dv/string_query_matcher_core_test.sv
// ----------------------------------------------------------------------------
// string_query_matcher_core_test
// Drives query settings and texts into the string query matcher: a short
// directed set covering empty texts and queries, character-less transactions,
// a mode change inside a text, the unused mode and an oversized length, then
// random texts built around the current query under many settings, with
// random gaps and back-pressure. Verdicts are checked by query_match_checker.
// ----------------------------------------------------------------------------
module string_query_matcher_core_test;
    import sqm_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 20;
    localparam int PHASE_ITEMS  = 80;
    localparam int TEXT_MAX     = 128;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [CHAR_W-1:0]      s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [7:0]             m_axis_tdata;

    logic                   jitter_on     = 1'b1;
    int                     items_sent    = 0;
    int                     texts_sent    = 0;
    int                     settings_used = 0;
    int                     quiet         = 0;
    int                     errors;
    int                     pending;
    int                     checked;
    int                     hits;

    logic [7:0]             query_chars[QUERY_BYTES];
    int                     query_span    = 0;
    t_mode                  mode_now      = MODE_PREFIX;

    logic [7:0]             text_buf[TEXT_MAX];
    int                     text_len      = 0;

    string_query_matcher_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    query_match_checker u_match_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_s_tlast   (s_axis_tlast),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_hits      (hits)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= !(jitter_on && ($urandom_range(99) < 8));
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("string_query_matcher_core_test: errors");
            $finish;
        end
    end

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        int         pick;
        pick = $urandom_range(9);
        if (pick < 5) c = query_chars[$urandom_range(QUERY_BYTES-1)];
        else if (pick < 8) c = 8'h61 + 8'($urandom_range(25));
        else c = 8'($urandom_range(255));
        if (is_letter(c) && ($urandom_range(1) == 1)) c = c ^ 8'h20;
        return c;
    endfunction

    task automatic stash_char(input logic [7:0] c);
        text_buf[text_len] = c;
        text_len++;
    endtask

    task automatic send_item(input logic [7:0] c, input logic present, input logic last);
        while (jitter_on && ($urandom_range(99) < 8)) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= present;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        items_sent++;
        if (last) texts_sent++;
    endtask

    task automatic cfg_put(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // stop sending, wait until no verdict is owed and let the input register empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic apply_setting(input logic [63:0] lo, input logic [63:0] hi,
                                 input logic [LEN_W-1:0] len, input t_mode mode,
                                 input logic fold, input logic pad_upper);
        logic [63:0] pad;
        int          k;
        settle();
        pad = pad_upper ? {$urandom, $urandom} : 64'd0;
        cfg_put(CFG_QUERY_LOW, lo);
        cfg_put(CFG_QUERY_HIGH, hi);
        cfg_put(CFG_QUERY_LEN, {pad[63:LEN_W], len});
        cfg_put(CFG_MODE, {pad[63:2], mode});
        cfg_put(CFG_CASE_FOLD, {pad[63:1], fold});
        i_cfg_valid <= 1'b0;
        for (k = 0; k < QUERY_BYTES; k++) begin
            query_chars[k] = (k < 8) ? lo[8*k +: 8] : hi[8*(k-8) +: 8];
        end
        query_span = (len > QUERY_MAX_DEF) ? QUERY_MAX_DEF : int'(len);
        mode_now   = mode;
        settings_used++;
    endtask

    // mostly texts that carry the query, possibly cut short, case-flipped,
    // corrupted or spread out, plus pure noise and empty texts
    task automatic send_random_text();
        logic [7:0] c;
        logic       trail;
        int         kind;
        int         lead;
        int         stop;
        int         k;
        text_len = 0;
        kind = $urandom_range(9);
        if (kind == 1) begin
            repeat ($urandom_range(1, 12)) stash_char(8'($urandom_range(255)));
        end else if (kind != 0) begin
            lead = ((mode_now == MODE_PREFIX) && ($urandom_range(3) != 0)) ? 0 :
                   $urandom_range(kind == 2 ? 30 : 4);
            stop = (kind == 3) ? $urandom_range(query_span) : query_span;
            repeat (lead) stash_char(noise_char());
            for (k = 0; k < stop; k++) begin
                if (((mode_now == MODE_FUZZY) && ($urandom_range(2) == 0)) ||
                    ($urandom_range(9) == 0)) begin
                    stash_char(noise_char());
                end
                c = query_chars[k];
                if (is_letter(c) && ($urandom_range(2) == 0)) c = c ^ 8'h20;
                if ($urandom_range(19) == 0) c = 8'($urandom_range(255));
                stash_char(c);
            end
            repeat ($urandom_range(4)) stash_char(noise_char());
        end
        if (text_len == 0) begin
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
        end else begin
            trail = ($urandom_range(9) == 0);
            for (k = 0; k < text_len; k++) begin
                if ($urandom_range(24) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
                send_item(text_buf[k], 1'b1, !trail && (k == text_len - 1));
            end
            if (trail) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
        end
    endtask

    initial begin
        logic [63:0]      lo;
        logic [63:0]      hi;
        logic [LEN_W-1:0] len;
        t_mode            mode;
        logic [7:0]       c;
        int               p;
        int               k;
        int               r;
        int               start;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty text under the reset settings
        send_item(8'hA5, 1'b0, 1'b1);
        // "Ab" as prefix with folding, character-less transaction mid text
        apply_setting(64'h6241, 64'h0, 5'd2, MODE_PREFIX, 1'b1, 1'b0);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h41, 1'b0, 1'b0);
        send_item(8'h42, 1'b1, 1'b1);
        // substring state carried into fuzzy mode within one text
        apply_setting(64'h6241, 64'h0, 5'd2, MODE_SUBSTRING, 1'b1, 1'b0);
        send_item(8'h78, 1'b1, 1'b0);
        send_item(8'h41, 1'b1, 1'b0);
        settle();
        cfg_put(CFG_MODE, {62'd0, MODE_FUZZY});
        i_cfg_valid <= 1'b0;
        mode_now = MODE_FUZZY;
        send_item(8'h59, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b1);
        // unused mode
        apply_setting(64'h6241, 64'h0, 5'd2, MODE_UNUSED, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        // oversized length with an all-ones query
        apply_setting('1, '1, 5'd31, MODE_PREFIX, 1'b0, 1'b1);
        for (k = 0; k < QUERY_MAX_DEF; k++) send_item(8'hFF, 1'b1, k == QUERY_MAX_DEF - 1);

        for (p = 0; p < PHASES; p++) begin
            jitter_on = !((p >= 6) && (p <= 9));
            for (k = 0; k < QUERY_BYTES; k++) begin
                c = ($urandom_range(9) < 7) ? 8'h61 + 8'($urandom_range(2)) :
                    8'($urandom_range(255));
                if (is_letter(c) && ($urandom_range(1) == 1)) c = c ^ 8'h20;
                if (k < 8) lo[8*k +: 8] = c;
                else hi[8*(k-8) +: 8] = c;
            end
            len = ($urandom_range(7) == 0) ? 5'($urandom_range(17, 31)) :
                  5'($urandom_range(QUERY_MAX_DEF));
            r = $urandom_range(9);
            mode = (r < 3) ? MODE_PREFIX : (r < 6) ? MODE_SUBSTRING :
                   (r < 9) ? MODE_FUZZY : MODE_UNUSED;
            if (p == 0) begin
                apply_setting('0, '0, 5'd16, MODE_SUBSTRING, 1'b0, 1'b0);
            end else if (p == 1) begin
                apply_setting(lo, hi, 5'd31, MODE_FUZZY, 1'b1, 1'b1);
            end else if (p == 2) begin
                apply_setting(lo, hi, 5'd0, MODE_PREFIX, 1'b1, 1'b0);
            end else begin
                apply_setting(lo, hi, len, mode, 1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) send_random_text();
        end
        jitter_on = 1'b1;
        settle();

        $display("ran %0d texts in %0d stream transactions under %0d query settings",
                 texts_sent, items_sent, settings_used);
        $display("checked %0d verdicts, %0d of them matches", checked, hits);
        if (errors == 0) begin
            $display("string_query_matcher_core_test: clean");
        end else begin
            $display("string_query_matcher_core_test: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/sqm_pkg.sv
design/sqm_cfg_regs.sv
design/sqm_match_engine.sv
design/string_query_matcher_core.sv
dv/query_match_checker.sv
dv/string_query_matcher_core_test.sv
